@@ hdl/skld_pkg.sv @@
// Shared constants, codes and item types for the substitution key block.
package skld_pkg;

   localparam int ALPHABET_SIZE = 26;
   localparam int IDX_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
   localparam int CNT_W = $clog2(ALPHABET_SIZE + 1);
   localparam logic [7:0] LETTER_BASE = 8'h41;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_LEARN = 2'd1;
   localparam logic [1:0] OP_TRANSLATE = 2'd2;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] plain_byte;
      logic [7:0] cipher_byte;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       failed;
      logic       key_complete;
   } rsp_item_type;

   typedef struct packed {
      logic [CNT_W-1:0] set_count;
      logic             conflict_flag;
      logic             duplicate_flag;
      logic             clear_take;
   } key_status_type;

endpackage

@@ hdl/skld_channels.sv @@
// Request and response channel interfaces.
interface skld_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] plain_byte;
   logic [7:0] cipher_byte;

   modport source (output valid, output opcode, output plain_byte, output cipher_byte,
                   input ready);
   modport sink (input valid, input opcode, input plain_byte, input cipher_byte,
                 output ready);
endinterface

interface skld_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       failed;
   logic       key_complete;

   modport source (output valid, output out_byte, output failed, output key_complete,
                   input ready);
   modport sink (input valid, input out_byte, input failed, input key_complete,
                 output ready);
endinterface

@@ hdl/skld_in_stage.sv @@
// Input register stage: captures one request and holds it until the core takes it.
module skld_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   skld_req_if.sink              req,
   input  logic                  advance,
   output logic                  stage_valid,
   output skld_pkg::req_item_type stage_item
);

   logic                   stage_valid_ff;
   logic                   stage_valid_in;
   skld_pkg::req_item_type stage_item_ff;
   logic                   take;

   assign req.ready = !stage_valid_ff || advance;
   assign take = req.valid && req.ready;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (take) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         stage_item_ff <= '{opcode: req.opcode, plain_byte: req.plain_byte,
                            cipher_byte: req.cipher_byte};
      end
   end

   assign stage_valid = stage_valid_ff;
   assign stage_item = stage_item_ff;

endmodule

@@ hdl/skld_core.sv @@
// Key state, learn/translate logic and the result register.
module skld_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    stage_valid,
   input  skld_pkg::req_item_type  stage_item,
   output logic                    advance,
   output skld_pkg::key_status_type status,
   skld_rsp_if.source              rsp
);

   logic [7:0]                   key_table_ff [skld_pkg::ALPHABET_SIZE];
   logic [skld_pkg::ALPHABET_SIZE-1:0] entry_set_ff;
   logic [skld_pkg::ALPHABET_SIZE-1:0] entry_set_in;
   logic                         conflict_ff;
   logic                         conflict_in;
   logic                         duplicate_ff;
   logic                         duplicate_in;
   logic [skld_pkg::CNT_W-1:0]   count_ff;
   logic [skld_pkg::CNT_W-1:0]   count_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   skld_pkg::rsp_item_type       rsp_item_ff;
   skld_pkg::rsp_item_type       rsp_item_in;

   logic                         fire;
   logic [7:0]                   diff;
   logic                         is_letter;
   logic [skld_pkg::IDX_W-1:0]   idx;
   logic                         entry_hit;
   logic [7:0]                   key_rd;
   logic                         learn_new;
   logic                         cipher_taken;
   logic                         complete;
   logic                         fail;

   assign advance = !rsp_valid_ff || rsp.ready;
   assign fire = stage_valid && advance;

   assign diff = stage_item.plain_byte - skld_pkg::LETTER_BASE;
   assign is_letter = (stage_item.plain_byte >= skld_pkg::LETTER_BASE)
                      && (diff < 8'(skld_pkg::ALPHABET_SIZE));
   assign idx = diff[skld_pkg::IDX_W-1:0];
   assign entry_hit = is_letter && entry_set_ff[idx];
   assign key_rd = is_letter ? key_table_ff[idx] : 8'h00;
   assign learn_new = fire && (stage_item.opcode == skld_pkg::OP_LEARN)
                      && is_letter && !entry_set_ff[idx];

   // A cipher byte is taken when some mapped letter already holds it.
   always_comb begin
      cipher_taken = 1'b0;
      for (int j = 0; j < skld_pkg::ALPHABET_SIZE; j++) begin
         if (entry_set_ff[j] && (key_table_ff[j] == stage_item.cipher_byte)) begin
            cipher_taken = 1'b1;
         end
      end
   end

   always_comb begin
      entry_set_in = entry_set_ff;
      conflict_in = conflict_ff;
      duplicate_in = duplicate_ff;
      count_in = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in = rsp_item_ff;
      complete = 1'b0;
      fail = 1'b0;

      if (fire && (stage_item.opcode == skld_pkg::OP_CLEAR)) begin
         entry_set_in = '0;
         conflict_in = 1'b0;
         duplicate_in = 1'b0;
         count_in = '0;
      end else if (learn_new) begin
         if (cipher_taken) begin
            duplicate_in = 1'b1;
         end
         entry_set_in[idx] = 1'b1;
         count_in = count_ff + 1'b1;
      end else if (fire && (stage_item.opcode == skld_pkg::OP_LEARN) && entry_hit
                   && (key_rd != stage_item.cipher_byte)) begin
         conflict_in = 1'b1;
      end

      complete = (count_in == skld_pkg::CNT_W'(skld_pkg::ALPHABET_SIZE));
      fail = conflict_in || duplicate_in;

      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_item_in.out_byte = 8'h00;
         rsp_item_in.key_complete = complete;
         rsp_item_in.failed = fail;
         if (stage_item.opcode == skld_pkg::OP_TRANSLATE) begin
            if (!complete || fail) begin
               rsp_item_in.failed = 1'b1;
            end else begin
               rsp_item_in.out_byte = is_letter ? key_rd : stage_item.plain_byte;
            end
         end
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_set_ff <= '0;
         conflict_ff <= 1'b0;
         duplicate_ff <= 1'b0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         entry_set_ff <= entry_set_in;
         conflict_ff <= conflict_in;
         duplicate_ff <= duplicate_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload only: key entries are used solely where entry_set marks them written.
   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
      if (learn_new) begin
         key_table_ff[idx] <= stage_item.cipher_byte;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.out_byte = rsp_item_ff.out_byte;
   assign rsp.failed = rsp_item_ff.failed;
   assign rsp.key_complete = rsp_item_ff.key_complete;

   assign status = '{set_count: count_ff, conflict_flag: conflict_ff,
                     duplicate_flag: duplicate_ff,
                     clear_take: fire && (stage_item.opcode == skld_pkg::OP_CLEAR)};

endmodule

@@ hdl/substitution_key_learn_and_decode_top.sv @@
// A request is captured in the input register; its response is held in the response register.
// Throughput: one request per cycle while rsp.ready holds; the key lookup and the
// used-byte compare against all mapped letters sit in one stage between the input register
// and the response register. Reset (synchronous, active high) empties the key marks, the
// set count and both sticky flags at once; no clearing pass follows.
module substitution_key_learn_and_decode_top (
   input  logic      clock,
   input  logic      reset,
   skld_req_if.sink  req,
   skld_rsp_if.source rsp
);

   logic                     advance;
   logic                     stage_valid;
   skld_pkg::req_item_type   stage_item;
   skld_pkg::key_status_type status;

   skld_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage_item  (stage_item)
   );

   skld_core u_core (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage_item  (stage_item),
      .advance     (advance),
      .status      (status),
      .rsp         (rsp)
   );

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      status.set_count <= skld_pkg::CNT_W'(skld_pkg::ALPHABET_SIZE))
      else $error("set count beyond alphabet size");

   a_byte_means_success: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.out_byte != 8'h00) |-> !rsp.failed && rsp.key_complete)
      else $error("nonzero response byte without a complete, clean key");

   a_dup_sticky: assert property (@(posedge clock) disable iff (reset)
      status.duplicate_flag && !status.clear_take |=> status.duplicate_flag)
      else $error("duplicate flag dropped without a clear");

   a_conflict_sticky: assert property (@(posedge clock) disable iff (reset)
      status.conflict_flag && !status.clear_take |=> status.conflict_flag)
      else $error("conflict flag dropped without a clear");

endmodule
